>>> src/lwfb_pkg.sv
// shared types, tables and crc function for the lamp write frame builder
package lwfb_pkg;

   localparam int LampCount  = 49;
   localparam int GroupCount = 6;
   localparam int NumWidth   = 6;
   localparam int CntWidth   = 4;
   localparam int PosWidth   = 5;
   localparam int CsrIdxWidth = 2;

   localparam logic [7:0]  DevAddrReset = 8'h01;
   localparam logic [7:0]  FuncCodeReset = 8'h46;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPolyRefl = 16'hA001;

   localparam logic [CsrIdxWidth-1:0] CsrDevAddr  = CsrIdxWidth'(0);
   localparam logic [CsrIdxWidth-1:0] CsrFuncCode = CsrIdxWidth'(1);

   localparam logic [PosWidth-1:0] PosDevAddr  = PosWidth'(0);
   localparam logic [PosWidth-1:0] PosFuncCode = PosWidth'(1);
   localparam logic [PosWidth-1:0] PosStartHi  = PosWidth'(2);
   localparam logic [PosWidth-1:0] PosStartLo  = PosWidth'(3);
   localparam logic [PosWidth-1:0] PosCountHi  = PosWidth'(4);
   localparam logic [PosWidth-1:0] PosCountLo  = PosWidth'(5);
   localparam logic [PosWidth-1:0] PosByteCnt  = PosWidth'(6);
   localparam logic [PosWidth-1:0] PosData     = PosWidth'(7);
   localparam logic [PosWidth-1:0] PosMax      = PosWidth'(28);

   localparam logic [7:0] LampAddr [0:LampCount-1] = '{
      8'd0,  8'd10, 8'd16, 8'd1,  8'd11, 8'd17, 8'd2,  8'd12, 8'd18, 8'd3,
      8'd13, 8'd19, 8'd4,  8'd14, 8'd20, 8'd5,  8'd15, 8'd21, 8'd6,  8'd7,
      8'd22, 8'd8,  8'd23, 8'd24, 8'd9,  8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
      8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42,
      8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51
   };

   localparam logic [7:0] GroupStart [0:GroupCount-1] = '{
      8'h00, 8'h09, 8'h0F, 8'h1C, 8'h24, 8'h2C
   };

   localparam logic [CntWidth-1:0] GroupLen [0:GroupCount-1] = '{
      4'd9, 4'd6, 4'd10, 4'd8, 4'd8, 4'd8
   };

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_last;
   } dp_status_type;

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPolyRefl;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> src/lwfb_ctrl.sv
// controller state machine sequencing one frame per request
module lwfb_ctrl
   import lwfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/lwfb_datapath.sv
// datapath: config registers, request decode, byte mux, crc and output register
module lwfb_datapath
   import lwfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]             csr_data,
   input  logic                   req_func,
   input  logic [NumWidth-1:0]    req_target_number,
   input  logic [7:0]             req_lamp_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_byte,
   output logic                   rsp_bad_request,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          sts
);

   logic [7:0]          dev_addr_ff, dev_addr_in;
   logic [7:0]          func_code_ff, func_code_in;
   logic                bad_ff, bad_in;
   logic [7:0]          start_ff, start_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [7:0]          low_ff, low_in;
   logic [15:0]         crc_ff, crc_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic                lamp_ok;
   logic                group_ok;
   logic [NumWidth-1:0] num_idx;
   logic [PosWidth-1:0] crc_pos;
   logic [7:0]          cur_byte;
   logic                cur_last;

   assign num_idx  = req_target_number - NumWidth'(1);
   assign lamp_ok  = (req_target_number != '0) && (req_target_number <= NumWidth'(LampCount));
   assign group_ok = (req_target_number != '0) && (req_target_number <= NumWidth'(GroupCount));
   assign crc_pos  = PosData + {count_ff, 1'b0};

   // byte at the current frame position
   always_comb begin
      cur_byte = 8'h00;
      if (bad_ff) begin
         cur_byte = 8'h00;
      end else if (pos_ff == PosDevAddr) begin
         cur_byte = dev_addr_ff;
      end else if (pos_ff == PosFuncCode) begin
         cur_byte = func_code_ff;
      end else if (pos_ff == PosStartLo) begin
         cur_byte = start_ff;
      end else if (pos_ff == PosCountLo) begin
         cur_byte = {4'h0, count_ff};
      end else if (pos_ff == PosByteCnt) begin
         cur_byte = {3'b000, count_ff, 1'b0};
      end else if (pos_ff == PosStartHi || pos_ff == PosCountHi) begin
         cur_byte = 8'h00;
      end else if (pos_ff < crc_pos) begin
         cur_byte = pos_ff[0] ? 8'h00 : low_ff;
      end else if (pos_ff == crc_pos) begin
         cur_byte = crc_ff[7:0];
      end else begin
         cur_byte = crc_ff[15:8];
      end
   end

   assign cur_last     = bad_ff || (pos_ff == crc_pos + PosWidth'(1));
   assign sts.is_last  = cur_last;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dev_addr_in  = dev_addr_ff;
      func_code_in = func_code_ff;
      bad_in       = bad_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CsrDevAddr:  dev_addr_in = csr_data;
            CsrFuncCode: func_code_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.load) begin
         pos_in = '0;
         crc_in = CrcInit;
         if (req_func) begin
            bad_in   = !group_ok;
            start_in = GroupStart[num_idx[2:0]];
            count_in = GroupLen[num_idx[2:0]];
            low_in   = {7'h00, (req_lamp_value != 8'h00)};
         end else begin
            bad_in   = !lamp_ok;
            start_in = LampAddr[num_idx];
            count_in = CntWidth'(1);
            low_in   = req_lamp_value;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.step) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = cur_last;
         rsp_bad_in   = bad_ff;
         pos_in       = pos_ff + PosWidth'(1);
         if (!bad_ff && pos_ff < crc_pos) begin
            crc_in = crc_next(crc_ff, cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DevAddrReset;
         func_code_ff <= FuncCodeReset;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         crc_ff       <= CrcInit;
         bad_ff       <= 1'b0;
         count_ff     <= '0;
      end else begin
         dev_addr_ff  <= dev_addr_in;
         func_code_ff <= func_code_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         bad_ff       <= bad_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      low_ff      <= low_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_byte  = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;
   assign rsp_bad_request = rsp_bad_ff;

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_last_ff)
      else $error("bad request result without last flag");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> pos_ff <= PosMax)
      else $error("frame position past end of longest frame");

   a_step_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> sts.out_free)
      else $error("byte stepped while output register is occupied");

   a_valid_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.step))
      else $error("result appeared without a step");

endmodule

>>> src/lamp_write_frame_builder_core.sv
// top level of the lamp write frame builder
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  func, target_number, lamp_value
//  rsp      out        rsp_valid/rsp_stall  frame_byte, last_byte, bad_request
//  csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one frame byte per cycle while rsp_stall is low; a single lamp frame has 11 bytes,
// a group frame 9 + 2 * lamp count bytes and a bad request one byte, all from the
// single byte sequencer and output register, which takes no new request mid-frame
// rsp_stall holds the output register and pauses the sequencer
// synchronous active-high reset restores register defaults and idles the block
module lamp_write_frame_builder_core
   import lwfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [NumWidth-1:0]    req_target_number,
   input  logic [7:0]             req_lamp_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_byte,
   output logic                   rsp_bad_request,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   lwfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lwfb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_func          (req_func),
      .req_target_number (req_target_number),
      .req_lamp_value    (req_lamp_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_bad_request   (rsp_bad_request),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

>>> sim/lamp_write_frame_builder_core_tb.sv
// testbench for the lamp write frame builder: directed and random requests, predicted frames
`timescale 1ns / 100ps

module lamp_write_frame_builder_core_tb;
   import lwfb_pkg::*;

   localparam int LongHold = 600;
   localparam int SettleCycles = 8;

   localparam logic [7:0] LampRegMap [0:48] = '{
      8'd0,  8'd10, 8'd16, 8'd1,  8'd11, 8'd17, 8'd2,  8'd12, 8'd18, 8'd3,
      8'd13, 8'd19, 8'd4,  8'd14, 8'd20, 8'd5,  8'd15, 8'd21, 8'd6,  8'd7,
      8'd22, 8'd8,  8'd23, 8'd24, 8'd9,  8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
      8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42,
      8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51
   };
   localparam logic [7:0] GroupRegStart [0:5] = '{8'h00, 8'h09, 8'h0F, 8'h1C, 8'h24, 8'h2C};
   localparam logic [7:0] GroupLampCount [0:5] = '{8'd9, 8'd6, 8'd10, 8'd8, 8'd8, 8'd8};

   typedef struct packed {
      logic                func;
      logic [NumWidth-1:0] target;
      logic [7:0]          value;
   } lamp_request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       bad;
   } frame_entry_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_func = 1'b0;
   logic [NumWidth-1:0]    req_target_number = '0;
   logic [7:0]             req_lamp_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_frame_byte;
   logic                   rsp_last_byte;
   logic                   rsp_bad_request;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [7:0]             csr_data = '0;

   lamp_request_type pending_reqs [$];
   frame_entry_type  frame_q [$];

   logic [7:0] dev_addr_m = DevAddrReset;
   logic [7:0] func_code_m = FuncCodeReset;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int fail_count = 0;
   int reqs_sent = 0;
   int bytes_checked = 0;
   int bad_seen = 0;
   int csr_writes = 0;

   lamp_write_frame_builder_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_target_number (req_target_number),
      .req_lamp_value    (req_lamp_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_bad_request   (rsp_bad_request),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** lamp_write_frame_builder_core: FAILED **");
      $finish;
   end

   function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      repeat (8) begin
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      end
      return r;
   endfunction

   task automatic push_frame_byte(input logic [7:0] d, input logic last, input logic bad);
      frame_entry_type e;
      e.data = d;
      e.last = last;
      e.bad = bad;
      frame_q.push_back(e);
   endtask

   task automatic predict_frame(input logic f, input logic [NumWidth-1:0] num,
                                input logic [7:0] val);
      logic [7:0]  body [$];
      logic [7:0]  start;
      logic [7:0]  count;
      logic [7:0]  lowbyte;
      logic [15:0] crc;
      if (num == 0 || (!f && num > 49) || (f && num > 6)) begin
         push_frame_byte(8'h00, 1'b1, 1'b1);
         return;
      end
      if (!f) begin
         start = LampRegMap[int'(num) - 1];
         count = 8'd1;
         lowbyte = val;
      end else begin
         start = GroupRegStart[int'(num) - 1];
         count = GroupLampCount[int'(num) - 1];
         lowbyte = (val != 8'h00) ? 8'h01 : 8'h00;
      end
      body.push_back(dev_addr_m);
      body.push_back(func_code_m);
      body.push_back(8'h00);
      body.push_back(start);
      body.push_back(8'h00);
      body.push_back(count);
      body.push_back(8'(count << 1));
      for (int i = 0; i < int'(count); i++) begin
         body.push_back(8'h00);
         body.push_back(lowbyte);
      end
      crc = 16'hFFFF;
      foreach (body[i]) begin
         crc = crc16_modbus_byte(crc, body[i]);
         push_frame_byte(body[i], 1'b0, 1'b0);
      end
      push_frame_byte(crc[7:0], 1'b0, 1'b0);
      push_frame_byte(crc[15:8], 1'b1, 1'b0);
   endtask

   // request driver
   always @(posedge clock) begin
      lamp_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_frame(req_func, req_target_number, req_lamp_value);
            reqs_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_func <= item.func;
               req_target_number <= item.target;
               req_lamp_value <= item.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result backpressure, with a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= LongHold;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      frame_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_q.size() == 0) begin
            $error("unexpected result transaction, frame_byte %0h", rsp_frame_byte);
            fail_count++;
         end else begin
            want = frame_q.pop_front();
            bytes_checked++;
            if (want.bad) bad_seen++;
            if (rsp_frame_byte !== want.data) begin
               $error("frame_byte expected %0h actual %0h", want.data, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_last_byte !== want.last) begin
               $error("last_byte expected %0b actual %0b", want.last, rsp_last_byte);
               fail_count++;
            end
            if (rsp_bad_request !== want.bad) begin
               $error("bad_request expected %0b actual %0b", want.bad, rsp_bad_request);
               fail_count++;
            end
         end
      end
   end

   task automatic queue_request(input logic f, input logic [NumWidth-1:0] t,
                                input logic [7:0] v);
      lamp_request_type r;
      r.func = f;
      r.target = t;
      r.value = v;
      pending_reqs.push_back(r);
   endtask

   function automatic lamp_request_type random_request();
      lamp_request_type r;
      int sel;
      sel = $urandom_range(99);
      r.value = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
      if (sel < 65) begin
         r.func = 1'b0;
         r.target = NumWidth'($urandom_range(49, 1));
      end else if (sel < 90) begin
         r.func = 1'b1;
         r.target = NumWidth'($urandom_range(6, 1));
      end else begin
         r.func = 1'($urandom);
         r.target = NumWidth'($urandom);
      end
      return r;
   endfunction

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
      if (idx == CsrDevAddr) begin
         dev_addr_m = val;
      end else if (idx == CsrFuncCode) begin
         func_code_m = val;
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || frame_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_random(input int n, input int spct, input int rpct);
      send_idle_pct = spct;
      recv_idle_pct = rpct;
      repeat (n) pending_reqs.push_back(random_request());
      wait_drained();
   endtask

   initial begin
      int guard;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, bad numbers, every group
      queue_request(1'b0, 6'd0,  8'h00);
      queue_request(1'b0, 6'd1,  8'h00);
      queue_request(1'b0, 6'd1,  8'hFF);
      queue_request(1'b0, 6'd49, 8'hAA);
      queue_request(1'b0, 6'd50, 8'h55);
      queue_request(1'b0, 6'd63, 8'hFF);
      queue_request(1'b0, 6'd25, 8'h0F);
      queue_request(1'b0, 6'd26, 8'hF0);
      queue_request(1'b1, 6'd0,  8'h00);
      queue_request(1'b1, 6'd1,  8'hFF);
      queue_request(1'b1, 6'd2,  8'h00);
      queue_request(1'b1, 6'd3,  8'h80);
      queue_request(1'b1, 6'd4,  8'h01);
      queue_request(1'b1, 6'd5,  8'h7F);
      queue_request(1'b1, 6'd6,  8'hFF);
      queue_request(1'b1, 6'd6,  8'h00);
      queue_request(1'b1, 6'd7,  8'hFF);
      queue_request(1'b1, 6'd63, 8'h00);
      wait_drained();

      write_reg(CsrDevAddr, 8'h00);
      write_reg(CsrFuncCode, 8'h00);
      run_random(80, 0, 0);

      write_reg(CsrDevAddr, 8'hFF);
      write_reg(CsrFuncCode, 8'hFF);
      run_random(90, 63, 0);

      write_reg(CsrDevAddr, 8'($urandom));
      write_reg(CsrFuncCode, 8'($urandom));
      run_random(90, 0, 63);

      // unmapped register indexes are ignored
      write_reg(CsrIdxWidth'(2), 8'($urandom));
      write_reg(CsrIdxWidth'(3), 8'($urandom));
      write_reg(CsrDevAddr, 8'($urandom));
      write_reg(CsrFuncCode, 8'($urandom));
      run_random(90, 25, 25);

      // long receiver hold while requests keep coming
      hold_requests++;
      run_random(30, 0, 0);

      write_reg(CsrDevAddr, DevAddrReset);
      write_reg(CsrFuncCode, FuncCodeReset);
      run_random(50, 25, 25);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (50) pending_reqs.push_back(random_request());

      guard = 0;
      while ((pending_reqs.size() != 0 || req_valid || frame_q.size() != 0) && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (frame_q.size() != 0) begin
         $error("%0d expected frame bytes never arrived", frame_q.size());
         fail_count++;
      end
      if (pending_reqs.size() != 0 || req_valid) begin
         $error("%0d requests never accepted", pending_reqs.size());
         fail_count++;
      end

      $display("run covered %0d requests, %0d frame bytes checked, %0d bad requests",
               reqs_sent, bytes_checked, bad_seen);
      $display("register writes %0d, idle phases none/sender/receiver/both, one long hold",
               csr_writes);
      if (fail_count == 0) begin
         $display("** lamp_write_frame_builder_core: PASSED **");
      end else begin
         $display("** lamp_write_frame_builder_core: FAILED **");
      end
      $finish;
   end

endmodule
